[rtl/mfcd_pkg.sv]
// ----------------------------------------------------------------------------
// mfcd_pkg
// Types and constants shared by the music frame command decoder files.
// ----------------------------------------------------------------------------
package mfcd_pkg;

    localparam int ACTION_W   = 2;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int KIND_W     = 4;
    localparam int NIBBLE_W   = 4;
    localparam int SEED_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_RES    = 3;
    localparam int CNT_W      = 2;

    // Input actions
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BYTE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_START  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_PAUSE  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_POINT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRI_LIMIT    = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_P1_PERIOD  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_P2_PERIOD  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_TRI_PERIOD = 4'd2;
    localparam logic [KIND_W-1:0] KIND_P1_VOLDUTY = 4'd3;
    localparam logic [KIND_W-1:0] KIND_P2_VOLDUTY = 4'd4;
    localparam logic [KIND_W-1:0] KIND_NOISE      = 4'd5;
    localparam logic [KIND_W-1:0] KIND_TRI_GATE   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_NOISE_MODE = 4'd7;
    localparam logic [KIND_W-1:0] KIND_SAMPLE     = 4'd8;
    localparam logic [KIND_W-1:0] KIND_KILL       = 4'd9;
    localparam logic [KIND_W-1:0] KIND_FRAME_DONE = 4'd10;
    localparam logic [KIND_W-1:0] KIND_REWOUND    = 4'd11;
    localparam logic [KIND_W-1:0] KIND_STOPPED    = 4'd12;

    typedef enum logic [13:0] {
        PH_IDLE    = 14'b00000000000001,
        PH_CONTROL = 14'b00000000000010,
        PH_P1_HI   = 14'b00000000000100,
        PH_P1_LO   = 14'b00000000001000,
        PH_P2_HI   = 14'b00000000010000,
        PH_P2_LO   = 14'b00000000100000,
        PH_TRI_HI  = 14'b00000001000000,
        PH_TRI_LO  = 14'b00000010000000,
        PH_SQ1     = 14'b00000100000000,
        PH_SQ2     = 14'b00001000000000,
        PH_NOISE   = 14'b00010000000000,
        PH_EXT     = 14'b00100000000000,
        PH_DMC_A   = 14'b01000000000000,
        PH_DMC_B   = 14'b10000000000000
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [BYTE_W-1:0]   pending_control;
        logic [WORD_W-1:0]   byte_position;
        logic [BYTE_W-1:0]   word_high_byte;
        logic                kill_pending;
        logic [BYTE_W-1:0]   sample_select;
        logic                playing;
        logic                active;
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0] track_length;
        logic [WORD_W-1:0] loop_point;
        logic              loop_enable;
        logic [WORD_W-1:0] tri_limit;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [WORD_W-1:0]   word_value;
        logic [NIBBLE_W-1:0] volume;
        logic [NIBBLE_W-1:0] table_index;
        logic [NIBBLE_W-1:0] sample_rate_index;
        logic [SEED_W-1:0]   sample_seed;
        logic                flag_bit;
        logic                last;
    } t_result;

    typedef t_result [MAX_RES-1:0] t_res_list;

endpackage

[rtl/mfcd_in_if.sv]
// ----------------------------------------------------------------------------
// mfcd_in_if
// Input channel: one action and stream byte per word.
// ----------------------------------------------------------------------------
interface mfcd_in_if;
    import mfcd_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   byte_value;

    modport source (output valid, action, byte_value, input ready);
    modport sink   (input valid, action, byte_value, output ready);
endinterface

[rtl/mfcd_out_if.sv]
// ----------------------------------------------------------------------------
// mfcd_out_if
// Result channel: one voice-update result per word.
// ----------------------------------------------------------------------------
interface mfcd_out_if;
    import mfcd_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [WORD_W-1:0]   word_value;
    logic [NIBBLE_W-1:0] volume;
    logic [NIBBLE_W-1:0] table_index;
    logic [NIBBLE_W-1:0] sample_rate_index;
    logic [SEED_W-1:0]   sample_seed;
    logic                flag_bit;
    logic                last;

    modport source (output valid, kind, word_value, volume, table_index,
                    sample_rate_index, sample_seed, flag_bit, last, input ready);
    modport sink   (input valid, kind, word_value, volume, table_index,
                    sample_rate_index, sample_seed, flag_bit, last, output ready);
endinterface

[rtl/mfcd_decode.sv]
// ----------------------------------------------------------------------------
// mfcd_decode
// Single-pass decode of one action: next parser state and up to three results.
// ----------------------------------------------------------------------------
module mfcd_decode (
    input  mfcd_pkg::t_state                    i_state,
    input  mfcd_pkg::t_cfg                      i_cfg,
    input  logic [mfcd_pkg::ACTION_W-1:0]       i_action,
    input  logic [mfcd_pkg::BYTE_W-1:0]         i_byte,
    output mfcd_pkg::t_state                    o_state,
    output mfcd_pkg::t_res_list                 o_res,
    output logic [mfcd_pkg::CNT_W-1:0]          o_cnt
);
    import mfcd_pkg::*;

    typedef struct packed {
        t_phase phase;
        logic   emit_gate;
        logic   emit_done;
    } t_adv;

    function automatic t_phase stage_phase(input logic [2:0] s);
        t_phase p;
        p = PH_IDLE;
        case (s)
            3'd0:    p = PH_P1_HI;
            3'd1:    p = PH_P2_HI;
            3'd2:    p = PH_TRI_HI;
            3'd3:    p = PH_SQ1;
            3'd4:    p = PH_SQ2;
            3'd5:    p = PH_NOISE;
            default: p = PH_IDLE;
        endcase
        return p;
    endfunction

    // Find the next announced field from stage 'from'; past the noise byte
    // the gate is always reported once no further field is announced, then either the extension byte or done.
    function automatic t_adv advance(input logic [BYTE_W-1:0] c, input logic [2:0] from);
        t_adv a;
        logic found;
        found       = 1'b0;
        a.phase     = PH_IDLE;
        a.emit_gate = 1'b0;
        a.emit_done = 1'b0;
        for (int s = 0; s < 6; s++) begin
            if (!found && (3'(s) >= from) && c[s]) begin
                found   = 1'b1;
                a.phase = stage_phase(3'(s));
            end
        end
        if (!found) begin
            a.emit_gate = 1'b1;
            if (c[7]) begin
                a.phase = PH_EXT;
            end else begin
                a.emit_done = 1'b1;
                a.phase     = PH_IDLE;
            end
        end
        return a;
    endfunction

    function automatic t_result mk(input logic [KIND_W-1:0] kind,
                                   input logic [WORD_W-1:0] word,
                                   input logic [NIBBLE_W-1:0] vol,
                                   input logic [NIBBLE_W-1:0] idx,
                                   input logic [NIBBLE_W-1:0] rate,
                                   input logic [SEED_W-1:0] seed,
                                   input logic flag);
        t_result r;
        r.kind              = kind;
        r.word_value        = word;
        r.volume            = vol;
        r.table_index       = idx;
        r.sample_rate_index = rate;
        r.sample_seed       = seed;
        r.flag_bit          = flag;
        r.last              = 1'b0;
        return r;
    endfunction

    t_state              st;
    t_result             res [MAX_RES];
    logic [CNT_W-1:0]    cnt;
    t_adv                adv;
    logic                adv_use;
    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   zero_w;
    t_result             r_none;

    always_comb begin
        st      = i_state;
        cnt     = '0;
        adv     = '{phase: PH_IDLE, emit_gate: 1'b0, emit_done: 1'b0};
        adv_use = 1'b0;
        zero_w  = '0;
        r_none  = mk(KIND_P1_PERIOD, zero_w, '0, '0, '0, '0, 1'b0);
        word    = {i_state.word_high_byte, i_byte};
        for (int k = 0; k < MAX_RES; k++) begin
            res[k] = r_none;
        end

        unique case (i_action)
            ACT_TICK: begin
                st.phase = PH_IDLE;
                if (i_state.active && i_state.playing) begin
                    if (i_state.byte_position >= i_cfg.track_length) begin
                        if (i_cfg.loop_enable) begin
                            st.byte_position = i_cfg.loop_point;
                            st.phase         = PH_CONTROL;
                            res[cnt] = mk(KIND_REWOUND, i_cfg.loop_point, '0, '0, '0, '0, 1'b0);
                            cnt = cnt + 2'd1;
                        end else begin
                            st.byte_position = '0;
                            st.playing       = 1'b0;
                            st.active        = 1'b0;
                            res[cnt] = mk(KIND_STOPPED, zero_w, '0, '0, '0, '0, 1'b0);
                            cnt = cnt + 2'd1;
                        end
                    end else begin
                        st.phase = PH_CONTROL;
                    end
                end
            end
            ACT_BYTE: begin
                if (i_state.phase != PH_IDLE) begin
                    st.byte_position = i_state.byte_position + WORD_W'(1);
                    unique case (i_state.phase)
                        PH_CONTROL: begin
                            st.pending_control = i_byte;
                            if (i_byte == '0) begin
                                res[cnt] = mk(KIND_FRAME_DONE, zero_w, '0, '0, '0, '0, 1'b0);
                                cnt = cnt + 2'd1;
                                st.phase = PH_IDLE;
                            end else begin
                                adv     = advance(i_byte, 3'd0);
                                adv_use = 1'b1;
                            end
                        end
                        PH_P1_HI: begin
                            st.word_high_byte = i_byte;
                            st.phase          = PH_P1_LO;
                        end
                        PH_P2_HI: begin
                            st.word_high_byte = i_byte;
                            st.phase          = PH_P2_LO;
                        end
                        PH_TRI_HI: begin
                            st.word_high_byte = i_byte;
                            st.phase          = PH_TRI_LO;
                        end
                        PH_P1_LO: begin
                            res[cnt] = mk(KIND_P1_PERIOD, word, '0, '0, '0, '0, 1'b0);
                            cnt = cnt + 2'd1;
                            adv     = advance(i_state.pending_control, 3'd1);
                            adv_use = 1'b1;
                        end
                        PH_P2_LO: begin
                            res[cnt] = mk(KIND_P2_PERIOD, word, '0, '0, '0, '0, 1'b0);
                            cnt = cnt + 2'd1;
                            adv     = advance(i_state.pending_control, 3'd2);
                            adv_use = 1'b1;
                        end
                        PH_TRI_LO: begin
                            // Clamp out-of-range triangle periods to zero
                            res[cnt] = mk(KIND_TRI_PERIOD,
                                          (word > i_cfg.tri_limit) ? zero_w : word,
                                          '0, '0, '0, '0, 1'b0);
                            cnt = cnt + 2'd1;
                            adv     = advance(i_state.pending_control, 3'd3);
                            adv_use = 1'b1;
                        end
                        PH_SQ1: begin
                            res[cnt] = mk(KIND_P1_VOLDUTY, zero_w, i_byte[3:0], i_byte[7:4],
                                          '0, '0, 1'b0);
                            cnt = cnt + 2'd1;
                            adv     = advance(i_state.pending_control, 3'd4);
                            adv_use = 1'b1;
                        end
                        PH_SQ2: begin
                            res[cnt] = mk(KIND_P2_VOLDUTY, zero_w, i_byte[3:0], i_byte[7:4],
                                          '0, '0, 1'b0);
                            cnt = cnt + 2'd1;
                            adv     = advance(i_state.pending_control, 3'd5);
                            adv_use = 1'b1;
                        end
                        PH_NOISE: begin
                            res[cnt] = mk(KIND_NOISE, zero_w, i_byte[3:0], i_byte[7:4],
                                          '0, '0, 1'b0);
                            cnt = cnt + 2'd1;
                            adv     = advance(i_state.pending_control, 3'd6);
                            adv_use = 1'b1;
                        end
                        PH_EXT: begin
                            res[cnt] = mk(KIND_NOISE_MODE, zero_w, '0, '0, '0, '0, i_byte[7]);
                            cnt = cnt + 2'd1;
                            st.kill_pending = i_byte[5];
                            if (i_byte[6]) begin
                                st.phase = PH_DMC_A;
                            end else begin
                                if (i_byte[5]) begin
                                    res[cnt] = mk(KIND_KILL, zero_w, '0, '0, '0, '0, 1'b0);
                                    cnt = cnt + 2'd1;
                                end
                                res[cnt] = mk(KIND_FRAME_DONE, zero_w, '0, '0, '0, '0, 1'b0);
                                cnt = cnt + 2'd1;
                                st.phase = PH_IDLE;
                            end
                        end
                        PH_DMC_A: begin
                            st.sample_select = i_byte;
                            st.phase         = PH_DMC_B;
                        end
                        PH_DMC_B: begin
                            res[cnt] = mk(KIND_SAMPLE, zero_w, '0,
                                          i_state.sample_select[3:0],
                                          i_state.sample_select[7:4],
                                          i_byte[6:0], i_byte[7]);
                            cnt = cnt + 2'd1;
                            if (i_state.kill_pending) begin
                                res[cnt] = mk(KIND_KILL, zero_w, '0, '0, '0, '0, 1'b0);
                                cnt = cnt + 2'd1;
                            end
                            res[cnt] = mk(KIND_FRAME_DONE, zero_w, '0, '0, '0, '0, 1'b0);
                            cnt = cnt + 2'd1;
                            st.phase = PH_IDLE;
                        end
                        default: begin
                            st.phase = PH_IDLE;
                        end
                    endcase
                    if (adv_use) begin
                        st.phase = adv.phase;
                        if (adv.emit_gate) begin
                            res[cnt] = mk(KIND_TRI_GATE, zero_w, '0, '0, '0, '0,
                                          st.pending_control[6]);
                            cnt = cnt + 2'd1;
                        end
                        if (adv.emit_done) begin
                            res[cnt] = mk(KIND_FRAME_DONE, zero_w, '0, '0, '0, '0, 1'b0);
                            cnt = cnt + 2'd1;
                        end
                    end
                end
            end
            ACT_START: begin
                if (!i_state.active) begin
                    st.active  = 1'b1;
                    st.playing = 1'b1;
                end
                st.byte_position = '0;
                st.phase         = PH_IDLE;
            end
            default: begin
                st.playing = ~i_state.playing;
            end
        endcase

        // Mark the final result of this action
        if (cnt != '0) begin
            res[cnt - 2'd1].last = 1'b1;
        end
    end

    assign o_state = st;
    assign o_cnt   = cnt;
    always_comb begin
        for (int k = 0; k < MAX_RES; k++) begin
            o_res[k] = res[k];
        end
    end

endmodule

[rtl/music_frame_command_decoder_top.sv]
// ----------------------------------------------------------------------------
// music_frame_command_decoder_top
// Per-frame command decoder for one music track driving a five-voice
// sound generator.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one word per action: a frame tick, a stream byte, a track
//   start or a pause toggle. o_out carries voice-update results, up to three
//   per input word, the final one flagged by last. The configuration port
//   (i_cfg_we, i_cfg_index, i_cfg_data) writes the track length, loop point,
//   loop enable and triangle period limit; write it only while idle.
//   An accepted input word waits in the input register, is decoded into the
//   result list, and its first result is then shown from the output register.
//   Throughput: while the result list is empty, a word that gives no result is
//   taken every cycle; a word with results holds the three-entry list until all
//   have left through the single result register; then the next word decodes.
//   Reset (synchronous, active low) clears the parser, position, play state
//   and both channels; the triangle limit returns to all ones.
//   When the receiver stalls the output register holds, the result list
//   fills, and i_in.ready drops once the input register is occupied.
// ----------------------------------------------------------------------------
module music_frame_command_decoder_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    mfcd_in_if.sink                            i_in,
    mfcd_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [mfcd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mfcd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mfcd_pkg::*;

    // Configuration
    t_cfg r_cfg;

    // Input register
    logic                r_in_vld;
    logic [ACTION_W-1:0] r_in_action;
    logic [BYTE_W-1:0]   r_in_byte;

    // Parser state
    t_state r_st;
    t_state n_st;

    // Result list and output register
    t_res_list        r_list;
    t_res_list        n_list;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_result          r_out;
    logic             r_out_vld;

    logic dec_fire;
    logic move;
    logic in_take;

    // Decode only when the list has fully drained into the output register
    assign dec_fire = r_in_vld && (r_cnt == '0);
    assign move     = (r_cnt != '0) && (!r_out_vld || o_out.ready);
    assign in_take  = i_in.valid && i_in.ready;

    assign i_in.ready = !r_in_vld || dec_fire;

    mfcd_decode u_decode (
        .i_state  (r_st),
        .i_cfg    (r_cfg),
        .i_action (r_in_action),
        .i_byte   (r_in_byte),
        .o_state  (n_st),
        .o_res    (n_list),
        .o_cnt    (n_cnt)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.track_length <= '0;
            r_cfg.loop_point   <= '0;
            r_cfg.loop_enable  <= 1'b0;
            r_cfg.tri_limit    <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TRACK_LENGTH: r_cfg.track_length <= i_cfg_data;
                CFG_LOOP_POINT:   r_cfg.loop_point   <= i_cfg_data;
                CFG_LOOP_ENABLE:  r_cfg.loop_enable  <= i_cfg_data[0];
                default:          r_cfg.tri_limit    <= i_cfg_data;
            endcase
        end
    end

    // Input register: hold the word until decode takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (dec_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_action <= i_in.action;
            r_in_byte   <= i_in.byte_value;
        end
    end

    // Parser state: advance on every decoded word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase           <= PH_IDLE;
            r_st.pending_control <= '0;
            r_st.byte_position   <= '0;
            r_st.word_high_byte  <= '0;
            r_st.kill_pending    <= 1'b0;
            r_st.sample_select   <= '0;
            r_st.playing         <= 1'b0;
            r_st.active          <= 1'b0;
        end else if (dec_fire) begin
            r_st <= n_st;
        end
    end

    // Result list: load on decode, shift towards the head on each move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (dec_fire) begin
            r_cnt <= n_cnt;
        end else if (move) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_fire) begin
            r_list <= n_list;
        end else if (move) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                r_list[k] <= r_list[k + 1];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (move) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= r_list[0];
        end
    end

    assign o_out.valid             = r_out_vld;
    assign o_out.kind              = r_out.kind;
    assign o_out.word_value        = r_out.word_value;
    assign o_out.volume            = r_out.volume;
    assign o_out.table_index       = r_out.table_index;
    assign o_out.sample_rate_index = r_out.sample_rate_index;
    assign o_out.sample_seed       = r_out.sample_seed;
    assign o_out.flag_bit          = r_out.flag_bit;
    assign o_out.last              = r_out.last;

endmodule
